FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition that holds at every clock edge out of reset.
`define TFE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that, when true, implies a consequence in the next cycle.
`define TFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that, when true, implies a consequence in the same cycle.
`define TFE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define TFE_ASSERT_ALWAYS(label, cond, msg)
`define TFE_ASSERT_NEXT(label, ante, cons, msg)
`define TFE_ASSERT_SAME(label, ante, cons, msg)

`endif

`endif

FILE: rtl/tfe_pkg.sv
`default_nettype none

package tfe_pkg;

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_EXTRACT = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [1:0] REG_TAG_BYTES     = 2'd0;
  localparam logic [1:0] REG_TAG_LENGTH    = 2'd1;
  localparam logic [1:0] REG_END_DELIMITER = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic [7:0] count;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/tag_field_extractor.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | data_byte, last_of_buffer
// out_    | output    | out_valid/out_stall| result_kind, out_byte, status,
//         |           |                    | extracted_count, is_last
// cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// One input word per cycle while in_stall is low; tag compare and state update finish in the accept cycle.
// Each word yields zero to two results into a 4-entry result queue, drained one per cycle while out_stall is low.
// Results are registered into the queue and appear on out_ once earlier queue entries have drained.
// in_stall is high while fewer than two queue slots are free.
// rst_n is synchronous, active low; registers reset to tag 0, length 1, delimiter 0.
`default_nettype none

`include "assert_macros.svh"

module tag_field_extractor #(
  parameter int MAX_TAG_LEN = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_out_byte,
  output logic [1:0]       out_status,
  output logic [7:0]       out_extracted_count,
  output logic             out_is_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam int WW = 8 * MAX_TAG_LEN;
  localparam int FW = $clog2(MAX_TAG_LEN + 1);

  logic [63:0]   tag_r;
  logic [3:0]    tag_len_r;
  logic [7:0]    delim_r;

  logic [WW-1:0] win_r, win_nxt, win_shift;
  logic [FW-1:0] fill_r, fill_nxt, fill_inc;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    cnt_r, cnt_nxt, cnt_inc;

  tfe_pkg::res_t q_r [tfe_pkg::QDEPTH];
  logic [tfe_pkg::QPW-1:0] wptr_r, rptr_r;
  logic [tfe_pkg::QCW-1:0] qcnt_r;

  tfe_pkg::res_t res0, res1;
  logic [1:0]    n_push;
  logic          in_acc, out_acc, match;
  logic [3:0]    len_eff;

  assign in_stall = qcnt_r > tfe_pkg::QCW'(tfe_pkg::QDEPTH - 2);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = qcnt_r != '0;
  assign out_acc   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r     <= '0;
      tag_len_r <= 4'd1;
      delim_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfe_pkg::REG_TAG_BYTES:     tag_r     <= cfg_wdata;
        tfe_pkg::REG_TAG_LENGTH:    tag_len_r <= cfg_wdata[3:0];
        tfe_pkg::REG_END_DELIMITER: delim_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tag_len_r == 4'd0) begin
      len_eff = 4'd1;
    end else if (tag_len_r > 4'(MAX_TAG_LEN)) begin
      len_eff = 4'(MAX_TAG_LEN);
    end else begin
      len_eff = tag_len_r;
    end
  end

  assign win_shift = WW'({win_r, in_data_byte});
  assign fill_inc  = (fill_r == FW'(MAX_TAG_LEN)) ? fill_r : fill_r + 1'b1;
  assign cnt_inc   = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;

  // newest byte in window byte 0 lines up with the final tag character
  always_comb begin
    logic [2:0] idx;
    match = 4'(fill_inc) >= len_eff;
    for (int p = 0; p < MAX_TAG_LEN; p++) begin
      idx = 3'(int'(len_eff) - 1 - p);
      if (p < int'(len_eff) && win_shift[8*p +: 8] != tag_r[8*idx +: 8]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    n_push    = 2'd0;
    res0      = '0;
    res1      = '0;
    if (in_acc) begin
      unique case (phase_r)
        tfe_pkg::PH_SEARCH: begin
          win_nxt  = win_shift;
          fill_nxt = fill_inc;
          if (match) begin
            phase_nxt = tfe_pkg::PH_EXTRACT;
            cnt_nxt   = '0;
          end
        end
        tfe_pkg::PH_EXTRACT: begin
          if (in_data_byte == delim_r) begin
            res0.kind   = tfe_pkg::KIND_STATUS;
            res0.status = tfe_pkg::ST_FOUND;
            res0.count  = cnt_r;
            n_push      = 2'd1;
            phase_nxt   = tfe_pkg::PH_DONE;
          end else begin
            cnt_nxt    = cnt_inc;
            res0.kind  = tfe_pkg::KIND_DATA;
            res0.data  = in_data_byte;
            res0.count = cnt_inc;
            n_push     = 2'd1;
            if (in_last_of_buffer) begin
              res1.kind   = tfe_pkg::KIND_STATUS;
              res1.status = tfe_pkg::ST_TRUNCATED;
              res1.count  = cnt_inc;
              n_push      = 2'd2;
            end
          end
        end
        default: ;
      endcase
      if (in_last_of_buffer) begin
        if (phase_r == tfe_pkg::PH_SEARCH) begin
          res0.kind   = tfe_pkg::KIND_STATUS;
          res0.status = match ? tfe_pkg::ST_TRUNCATED : tfe_pkg::ST_NOT_FOUND;
          res0.count  = '0;
          n_push      = 2'd1;
        end
        win_nxt   = '0;
        fill_nxt  = '0;
        phase_nxt = tfe_pkg::PH_SEARCH;
        cnt_nxt   = '0;
      end
      res0.last = n_push == 2'd1;
      res1.last = n_push == 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      phase_r <= tfe_pkg::PH_SEARCH;
      cnt_r   <= '0;
    end else begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wptr_r + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      wptr_r <= wptr_r + tfe_pkg::QPW'(n_push);
      rptr_r <= rptr_r + tfe_pkg::QPW'(out_acc);
      qcnt_r <= qcnt_r + tfe_pkg::QCW'(n_push) - tfe_pkg::QCW'(out_acc);
    end
  end

  assign out_result_kind     = q_r[rptr_r].kind;
  assign out_out_byte        = q_r[rptr_r].data;
  assign out_status          = q_r[rptr_r].status;
  assign out_extracted_count = q_r[rptr_r].count;
  assign out_is_last         = q_r[rptr_r].last;

  `TFE_ASSERT_ALWAYS(a_qcnt_bound, qcnt_r <= tfe_pkg::QCW'(tfe_pkg::QDEPTH), "result queue overflow")
  `TFE_ASSERT_SAME(a_extract_fill, phase_r == tfe_pkg::PH_EXTRACT, fill_r != '0, "extract without window fill")
  `TFE_ASSERT_NEXT(a_last_clears, in_acc && in_last_of_buffer, phase_r == tfe_pkg::PH_SEARCH && fill_r == '0 && win_r == '0, "buffer end did not clear matcher")

endmodule

`default_nettype wire
